>>> rtl/lfte_pkg.sv
// Package for the LED fade engine: request codes, widths, state enum.
// No dependencies.
package lfte_pkg;
  localparam int MaxColors = 8;
  localparam int SlotW = 3;
  localparam int CntW = 4;
  localparam logic [16:0] OneQ16 = 17'h10000;
  localparam logic [16:0] FracMinQ16 = 17'd655;

  typedef enum logic [2:0] {
    REQ_LOAD  = 3'd0,
    REQ_START = 3'd1,
    REQ_TICK  = 3'd2,
    REQ_ABORT = 3'd3,
    REQ_FORCE = 3'd4
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_T, ST_SQ, ST_POLY, ST_BRI, ST_DIV_F, ST_DIV_CP,
    ST_COL_RD, ST_COL_WR, ST_REPORT, ST_START
  } state_t;
endpackage

>>> rtl/lfte_div.sv
// Restoring divider, one quotient bit per cycle: q = floor(num / den).
// Depends on nothing but its ports.
module lfte_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [47:0] quo
);
  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [32:0] trial;

  assign trial = {rem_r[31:0], q_r[47]};
  always_comb begin
    rem_nxt = trial;
    q_nxt = {q_r[46:0], 1'b0};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end
  assign quo = q_r;
endmodule

>>> rtl/led_fade_transition_engine_unit.sv
// LED fade engine top level: colour memories, sequencer, result stage.
// Depends on lfte_pkg and lfte_div.
//
// Input channel in_*: one request word per handshake (valid high, stall low).
// Result channel out_*: one word per colour in use (one word when none);
// out_last marks the final word of a request. Config channel cfg_* writes
// effect_time_ms when the block is idle.
// Every request is accepted, then each result word takes a row read, a
// read-data step and an emit: loads, aborts, forces and idle ticks need
// nothing more.
// A start copies or clears eight memory rows, a read and a write each, before the results.
// A tick inside a fade runs up to three 48-step divisions in the shared
// serial divider, then one read and one write per colour, before the
// results. One request is in flight at a time.
// Reset clears all control state and the eight-entry valid bits of the
// colour memories; an entry that is not valid reads as zero.
// A stall on the result channel holds the word and the sequencer waits.
module led_fade_transition_engine_unit
  import lfte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [2:0]  in_color_slot,
  input  logic [31:0] in_color_value,
  input  logic [7:0]  in_target_brightness,
  input  logic [3:0]  in_color_count,
  input  logic [31:0] in_duration_ms,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_brightness,
  output logic [2:0]  out_out_slot,
  output logic [31:0] out_out_color,
  output logic        out_active,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  // memories: start, goal, current colours
  logic [31:0] start_mem [MaxColors];
  logic [31:0] goal_mem  [MaxColors];
  logic [31:0] cur_mem   [MaxColors];
  logic [MaxColors-1:0] sv_r, gv_r, cv_r;
  logic [31:0] s_rd_r, g_rd_r, c_rd_r;
  logic s_vrd_r, g_vrd_r, c_vrd_r;
  logic [31:0] s_rd, g_rd, c_rd;
  logic [SlotW-1:0] rd_addr;
  logic rd_en;
  logic s_we, g_we, c_we;
  logic [SlotW-1:0] s_wa, g_wa, c_wa;
  logic [31:0] s_wd, g_wd, c_wd;

  state_t st_r, st_nxt;
  logic [31:0] eff_r;
  logic        act_r;
  logic [31:0] t0_r, len_r;
  logic [7:0]  sb_r, gb_r, cb_r;
  logic [CntW-1:0] nuse_r;
  logic [2:0]  req_r;
  logic [2:0]  slot_r;
  logic [31:0] cval_r, now_r, dur_r;
  logic [7:0]  tb_r;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] idx_r;
  logic        rdp_r;
  logic [16:0] t_r, p_r, frac_r, cp_r;
  logic [33:0] sq_r;
  logic        ease_r;
  logic [CntW-1:0] cnt_sat;

  // output register
  logic        ov_r, ol_r, oa_r;
  logic [2:0]  osl_r;
  logic [31:0] oc_r;
  logic [7:0]  ob_r;

  // divider
  logic        dv_start, dv_done;
  logic [47:0] dv_num, dv_quo;
  logic [31:0] dv_den;
  lfte_div u_div (.clk, .rst_n, .start(dv_start), .num(dv_num), .den(dv_den),
                  .done(dv_done), .quo(dv_quo));

  assign in_stall  = (st_r != ST_IDLE);
  assign cfg_ready = (st_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_brightness = ob_r;
  assign out_out_slot = osl_r;
  assign out_out_color = oc_r;
  assign out_active = oa_r;
  assign out_last = ol_r;

  assign s_rd = s_vrd_r ? s_rd_r : 32'd0;
  assign g_rd = g_vrd_r ? g_rd_r : 32'd0;
  assign c_rd = c_vrd_r ? c_rd_r : 32'd0;

  // memory read/write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      s_rd_r <= start_mem[rd_addr];
      g_rd_r <= goal_mem[rd_addr];
      c_rd_r <= cur_mem[rd_addr];
    end
    if (s_we) start_mem[s_wa] <= s_wd;
    if (g_we) goal_mem[g_wa] <= g_wd;
    if (c_we) cur_mem[c_wa] <= c_wd;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0; gv_r <= '0; cv_r <= '0;
      s_vrd_r <= 1'b0; g_vrd_r <= 1'b0; c_vrd_r <= 1'b0;
    end else begin
      if (rd_en) begin
        s_vrd_r <= sv_r[rd_addr];
        g_vrd_r <= gv_r[rd_addr];
        c_vrd_r <= cv_r[rd_addr];
      end
      if (s_we) sv_r[s_wa] <= 1'b1;
      if (g_we) gv_r[g_wa] <= 1'b1;
      if (c_we) cv_r[c_wa] <= 1'b1;
    end
  end

  // byte blend
  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [16:0] p);
    logic [33:0] v;
    v = 34'((OneQ16 - p) * a) + 34'(p * b) + 34'd32768;
    lerp8 = (v[33:16] > 18'd255) ? 8'd255 : v[23:16];
  endfunction

  logic [31:0] blend;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      blend[8*k +: 8] = lerp8(s_rd[8*k +: 8], g_rd[8*k +: 8], cp_r);
    end
  end

  logic [31:0] elapsed;
  logic [16:0] one_m_t;
  logic [49:0] poly;
  logic [7:0]  bri;
  logic [CntW-1:0] nrep;
  logic        do_emit;
  logic [31:0] emit_col;
  logic        emit_last;

  assign elapsed = now_r - t0_r;
  assign one_m_t = OneQ16 - t_r;
  assign poly = 50'(sq_r[31:0]) * 50'(18'd196608 - {t_r, 1'b0}) + 50'h80000000;
  assign bri = lerp8(sb_r, gb_r, p_r);
  assign nrep = (nuse_r > CntW'(MaxColors)) ? CntW'(MaxColors) : nuse_r;
  assign cnt_sat = (cnt_r > CntW'(MaxColors)) ? CntW'(MaxColors) : cnt_r;
  assign emit_last = (nrep == 0) || (idx_r + 1'b1 == nrep);

  // sequencer
  always_comb begin
    st_nxt = st_r;
    rd_en = 1'b0; rd_addr = idx_r[SlotW-1:0];
    s_we = 1'b0; c_we = 1'b0;
    s_wa = idx_r[SlotW-1:0]; g_wa = slot_r; c_wa = idx_r[SlotW-1:0];
    s_wd = c_rd; g_wd = cval_r; c_wd = g_rd;
    dv_start = 1'b0; dv_num = {elapsed, 16'd0}; dv_den = len_r;
    do_emit = 1'b0; emit_col = c_rd;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          st_nxt = ST_COL_RD;
          if (in_req_type == REQ_START) st_nxt = ST_START;
          if (in_req_type == REQ_TICK) st_nxt = ST_DIV_T;
        end
      end
      ST_START: begin
        // copy/clear rows, a read step then a write step per row
        if (!rdp_r) begin
          rd_en = 1'b1;
        end else begin
          s_we = 1'b1;
          s_wd = (cnt_sat != nuse_r) ? 32'd0 : c_rd;
          if (cnt_sat != nuse_r && idx_r >= nuse_r) begin
            c_we = 1'b1; c_wd = 32'd0;
          end
          if (idx_r == CntW'(MaxColors - 1)) st_nxt = ST_COL_RD;
        end
      end
      ST_DIV_T: begin
        if (!act_r) st_nxt = ST_COL_RD;
        else if (elapsed >= len_r) st_nxt = ST_COL_WR;
        else if (!rdp_r) dv_start = 1'b1;
        else if (dv_done) st_nxt = ST_SQ;
      end
      ST_SQ: st_nxt = ST_POLY;
      ST_POLY: st_nxt = ST_BRI;
      ST_BRI: begin
        if (eff_r != 32'd0 && eff_r < len_r) begin
          st_nxt = ST_DIV_F;
          dv_start = 1'b1;
          dv_num = {eff_r, 16'd0};
        end else begin
          st_nxt = ST_DIV_CP;
        end
      end
      ST_DIV_F: if (dv_done) st_nxt = ST_DIV_CP;
      ST_DIV_CP: begin
        dv_num = {15'd0, p_r, 16'd0};
        dv_den = {15'd0, frac_r};
        if (p_r >= frac_r) st_nxt = ST_COL_WR;
        else if (!rdp_r) dv_start = 1'b1;
        else if (dv_done) st_nxt = ST_COL_WR;
      end
      ST_COL_WR: begin
        // update current colours (snap when done or cp is one)
        if (idx_r >= nrep) begin
          st_nxt = ST_COL_RD;
        end else if (!rdp_r) begin
          rd_en = 1'b1;
        end else begin
          c_we = 1'b1;
          c_wd = (cp_r == OneQ16) ? g_rd : blend;
        end
      end
      ST_COL_RD: begin
        if (!rdp_r) begin
          rd_en = 1'b1;
        end else begin
          st_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (!ov_r || !out_stall) begin
          do_emit = 1'b1;
          emit_col = (nrep == 0) ? 32'd0 : c_rd;
          st_nxt = emit_last ? ST_IDLE : ST_COL_RD;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      eff_r <= '0; act_r <= 1'b0; t0_r <= '0; len_r <= '0;
      sb_r <= '0; gb_r <= '0; cb_r <= '0; nuse_r <= '0;
      idx_r <= '0; rdp_r <= 1'b0;
      ov_r <= 1'b0; ol_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) eff_r <= cfg_data;
      if (do_emit) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          idx_r <= '0; rdp_r <= 1'b0;
          if (in_valid) begin
            req_r <= in_req_type; slot_r <= in_color_slot;
            cval_r <= in_color_value; tb_r <= in_target_brightness;
            cnt_r <= in_color_count; dur_r <= in_duration_ms;
            now_r <= in_now_ms;
            if (in_req_type == REQ_ABORT) act_r <= 1'b0;
            if (in_req_type == REQ_FORCE) cb_r <= in_target_brightness;
          end
        end
        ST_START: begin
          rdp_r <= !rdp_r;
          if (rdp_r) begin
            if (idx_r == CntW'(MaxColors - 1)) begin
              idx_r <= '0;
              sb_r <= cb_r; gb_r <= tb_r; t0_r <= now_r;
              len_r <= dur_r; act_r <= 1'b1; nuse_r <= cnt_sat;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        ST_DIV_T: begin
          cp_r <= OneQ16;
          if (act_r && elapsed >= len_r) begin
            cb_r <= gb_r; act_r <= 1'b0;
          end else if (act_r) begin
            if (!rdp_r) rdp_r <= 1'b1;
            else if (dv_done) begin
              rdp_r <= 1'b0;
              t_r <= dv_quo[16:0];
              ease_r <= (sb_r != 8'd0) && (gb_r == 8'd0);
            end
          end
        end
        ST_SQ: sq_r <= ease_r ? 34'(one_m_t * one_m_t) : 34'(t_r * t_r);
        ST_POLY: begin
          if (ease_r) p_r <= OneQ16 - 17'((sq_r + 34'd32768) >> 16);
          else p_r <= (poly[49:32] > 18'(OneQ16)) ? OneQ16 : poly[48:32];
        end
        ST_BRI: begin
          cb_r <= bri;
          frac_r <= OneQ16;
        end
        ST_DIV_F: if (dv_done) begin
          frac_r <= (dv_quo[16:0] < FracMinQ16) ? FracMinQ16 : dv_quo[16:0];
        end
        ST_DIV_CP: begin
          if (p_r >= frac_r) cp_r <= OneQ16;
          else if (!rdp_r) rdp_r <= 1'b1;
          else if (dv_done) begin
            rdp_r <= 1'b0;
            cp_r <= dv_quo[16:0];
          end
        end
        ST_COL_WR: begin
          if (idx_r >= nrep) begin
            idx_r <= '0; rdp_r <= 1'b0;
          end else begin
            rdp_r <= !rdp_r;
            if (rdp_r) idx_r <= idx_r + 1'b1;
          end
        end
        ST_COL_RD: rdp_r <= !rdp_r;
        ST_REPORT: begin
          if (!ov_r || !out_stall) begin
            ol_r <= emit_last; ob_r <= cb_r; oa_r <= act_r;
            osl_r <= idx_r[SlotW-1:0]; oc_r <= emit_col;
            idx_r <= idx_r + 1'b1;
            rdp_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // goal load writes happen in the first report-read cycle
  always_comb begin
    g_we = (st_r == ST_COL_RD) && !rdp_r && (idx_r == '0) && (req_r == REQ_LOAD)
           && (slot_r < SlotW'(MaxColors - 1) || slot_r == SlotW'(MaxColors - 1));
  end

  // output word holds under stall
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_out_color))
    else $error("result word changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> in_stall)
    else $error("input accepted while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_out_slot == SlotW'(nrep == 0 ? 0 : nrep - 1'b1))
    else $error("last word on wrong slot");
endmodule

>>> tb/tb_top.sv
// Self-checking bench for led_fade_transition_engine_unit: directed table, then random fades.
// Depends on lfte_pkg and the RTL top; a built-in predictor produces the expected result words.
module tb_top
  import lfte_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 4000;
  localparam int RandItems = 260;
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam bit [63:0] One = 64'h10000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_req_type = '0;
  logic [2:0] in_color_slot = '0;
  logic [31:0] in_color_value = '0;
  logic [7:0] in_target_brightness = '0;
  logic [3:0] in_color_count = '0;
  logic [31:0] in_duration_ms = '0;
  logic [31:0] in_now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_brightness;
  logic [2:0] out_out_slot;
  logic [31:0] out_out_color;
  logic out_active;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  led_fade_transition_engine_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one expected result word
  typedef struct packed {
    logic [7:0] bri;
    logic [2:0] slot;
    logic [31:0] color;
    logic act;
    logic last;
  } led_word_t;

  led_word_t pending_words[$];

  // predictor state
  logic [31:0] fx_effect;
  logic fx_active;
  logic [31:0] fx_start_t, fx_len;
  logic [7:0] fx_bri0, fx_bri_goal, fx_bri;
  int unsigned fx_ncol;
  logic [31:0] fx_col0[8], fx_col_goal[8], fx_col[8];

  int mismatches = 0;
  int items_sent = 0;
  int words_seen = 0;
  int fades = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit stall_quiet = 0;

  function automatic bit [7:0] lerp8(bit [63:0] a, bit [63:0] b, bit [63:0] p);
    bit [63:0] v;
    v = ((One - p) * a + p * b + 64'd32768) >> 16;
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [31:0] blend_rgbw(logic [31:0] s, logic [31:0] g, bit [63:0] cp);
    logic [31:0] r;
    for (int k = 0; k < 4; k++) r[8*k +: 8] = lerp8(s[8*k +: 8], g[8*k +: 8], cp);
    return r;
  endfunction

  function automatic void fade_tick(logic [31:0] now_v);
    logic [31:0] elapsed;
    bit [63:0] t, p, u, frac, cp;
    if (!fx_active) return;
    elapsed = now_v - fx_start_t;
    if (elapsed >= fx_len) begin
      fx_bri = fx_bri_goal;
      for (int i = 0; i < fx_ncol; i++) fx_col[i] = fx_col_goal[i];
      fx_active = 0;
      return;
    end
    t = {16'd0, elapsed, 16'd0} / fx_len;
    if (fx_bri0 > 0 && fx_bri_goal == 0) begin
      u = One - t;
      p = One - ((u * u + 64'd32768) >> 16);
    end else begin
      p = (t * t * (3 * One - 2 * t) + 64'h8000_0000) >> 32;
    end
    if (p > One) p = One;
    fx_bri = lerp8(fx_bri0, fx_bri_goal, p);
    frac = One;
    if (fx_effect > 0 && fx_effect < fx_len) begin
      frac = {16'd0, fx_effect, 16'd0} / fx_len;
      if (frac < 655) frac = 655;
    end
    cp = (p < frac) ? (p << 16) / frac : One;
    for (int i = 0; i < fx_ncol; i++)
      fx_col[i] = (cp < One) ? blend_rgbw(fx_col0[i], fx_col_goal[i], cp) : fx_col_goal[i];
  endfunction

  // apply one request word to the predictor and queue its results
  function automatic void predict_fade(logic [2:0] rq, logic [2:0] slot, logic [31:0] val,
                                       logic [7:0] tb, logic [3:0] cnt, logic [31:0] dur,
                                       logic [31:0] now_v);
    int unsigned c, n;
    led_word_t w;
    case (req_t'(rq))
      REQ_LOAD: fx_col_goal[slot] = val;
      REQ_START: begin
        c = (cnt > MaxColors) ? MaxColors : cnt;
        fx_bri0 = fx_bri;
        fx_bri_goal = tb;
        fx_start_t = now_v;
        fx_len = dur;
        fx_active = 1;
        for (int i = 0; i < MaxColors; i++) begin
          if (c != fx_ncol) begin
            fx_col0[i] = 0;
            if (i >= fx_ncol) fx_col[i] = 0;
          end else begin
            fx_col0[i] = fx_col[i];
          end
        end
        fx_ncol = c;
        fades++;
      end
      REQ_TICK: fade_tick(now_v);
      REQ_ABORT: fx_active = 0;
      REQ_FORCE: fx_bri = tb;
      default: ;
    endcase
    n = (fx_ncol == 0) ? 1 : fx_ncol;
    for (int i = 0; i < n; i++) begin
      w.bri = fx_bri;
      w.slot = i[2:0];
      w.color = (fx_ncol == 0) ? 32'd0 : fx_col[i];
      w.act = fx_active;
      w.last = (i + 1 == n);
      pending_words.push_back(w);
    end
  endfunction

  // send one request word, honoring a random gap and in_stall
  task automatic send_req(logic [2:0] rq, logic [2:0] slot, logic [31:0] val, logic [7:0] tb,
                          logic [3:0] cnt, logic [31:0] dur, logic [31:0] now_v);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid <= 1'b1;
    in_req_type <= rq;
    in_color_slot <= slot;
    in_color_value <= val;
    in_target_brightness <= tb;
    in_color_count <= cnt;
    in_duration_ms <= dur;
    in_now_ms <= now_v;
    do @(posedge clk); while (in_stall);
    predict_fade(rq, slot, val, tb, cnt, dur, now_v);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_effect(logic [31:0] v);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    fx_effect = v;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // result stall pattern
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      led_word_t e;
      words_seen++;
      stall_left <= stall_quiet ? 0 : $urandom_range(0, 12);
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: bri %0d slot %0d color %h",
                                       out_brightness, out_out_slot, out_out_color);
      end else begin
        e = pending_words.pop_front();
        if (e.bri !== out_brightness || e.slot !== out_out_slot || e.color !== out_out_color
            || e.act !== out_active || e.last !== out_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp bri %0d slot %0d color %h act %b last %b, got %0d %0d %h %b %b",
                     e.bri, e.slot, e.color, e.act, e.last, out_brightness, out_out_slot,
                     out_out_color, out_active, out_last);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // directed table
  typedef struct {
    logic [2:0] rq;
    logic [2:0] slot;
    logic [31:0] val;
    logic [7:0] tb;
    logic [3:0] cnt;
    logic [31:0] dur;
    logic [31:0] now_v;
    bit chk;
    logic [7:0] bri;
    logic act;
  } req_row_t;

  req_row_t dir_rows[] = '{
    '{REQ_TICK, 0, 0, 0, 0, 0, 0, 1, 0, 0},
    '{REQ_FORCE, 0, 0, 255, 0, 0, 0, 1, 255, 0},
    '{REQ_LOAD, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0},
    '{REQ_LOAD, 7, 32'h1234_5678, 0, 0, 0, 0, 0, 0, 0},
    '{REQ_LOAD, 3, 32'h80FF_0001, 0, 0, 0, 0, 0, 0, 0},
    '{REQ_START, 0, 0, 0, 15, 100, 32'hFFFF_FFF0, 1, 255, 1},
    '{REQ_TICK, 0, 0, 0, 0, 0, 32'h0000_0020, 0, 0, 0},
    '{REQ_TICK, 0, 0, 0, 0, 0, 32'h0000_0054, 1, 0, 0},
    '{REQ_SPARE_LO, 7, 32'hFFFF_FFFF, 255, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0},
    '{REQ_SPARE_HI, 0, 0, 0, 0, 0, 0, 1, 0, 0},
    '{REQ_START, 0, 0, 200, 8, 0, 5, 0, 0, 0},
    '{REQ_TICK, 0, 0, 0, 0, 0, 5, 1, 200, 0},
    '{REQ_START, 0, 0, 10, 2, 1000, 0, 1, 200, 1},
    '{REQ_FORCE, 0, 0, 77, 0, 0, 0, 1, 77, 1},
    '{REQ_LOAD, 1, 32'h00FF_00FF, 0, 0, 0, 0, 0, 0, 0},
    '{REQ_TICK, 0, 0, 0, 0, 0, 500, 0, 0, 0},
    '{REQ_ABORT, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{REQ_TICK, 0, 0, 0, 0, 0, 900, 0, 0, 0},
    '{REQ_START, 0, 0, 128, 0, 32'hFFFF_FFFF, 0, 0, 0, 0},
    '{REQ_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFFE, 0, 0, 0},
    '{REQ_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 128, 0}
  };

  // one well-formed fade with random content, plus some noise
  task automatic random_fade();
    logic [31:0] base, dur, now_v;
    int nload, nticks;
    base = $urandom;
    case ($urandom_range(0, 9))
      0: dur = $urandom;
      1: dur = $urandom_range(0, 3);
      default: dur = $urandom_range(4, 3000);
    endcase
    nload = $urandom_range(0, 4);
    for (int i = 0; i < nload; i++) send_req(REQ_LOAD, 3'($urandom), $urandom, 8'd0, 4'd0,
                                             32'd0, 32'd0);
    send_req(REQ_START, 3'd0, 32'd0, ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom),
             ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8)),
             dur, base);
    nticks = $urandom_range(2, 7);
    now_v = base;
    for (int i = 0; i < nticks; i++) begin
      now_v = now_v + (dur / nticks) + $urandom_range(0, dur / 8 + 1);
      case ($urandom_range(0, 11))
        0: send_req(3'($urandom), 3'($urandom), $urandom, 8'($urandom), 4'($urandom),
                    $urandom, $urandom);
        1: send_req(REQ_FORCE, 3'd0, 32'd0, 8'($urandom), 4'd0, 32'd0, 32'd0);
        2: send_req(REQ_LOAD, 3'($urandom), $urandom, 8'd0, 4'd0, 32'd0, 32'd0);
        3: if ($urandom_range(0, 2) == 0) send_req(REQ_ABORT, 3'd0, 32'd0, 8'd0, 4'd0,
                                                   32'd0, 32'd0);
        default: ;
      endcase
      send_req(REQ_TICK, 3'd0, 32'd0, 8'd0, 4'd0, 32'd0, now_v);
    end
  endtask

  initial begin
    logic [31:0] effects[4];
    req_row_t r;
    fx_effect = 0;
    fx_active = 0;
    fx_start_t = 0;
    fx_len = 0;
    fx_bri0 = 0;
    fx_bri_goal = 0;
    fx_bri = 0;
    fx_ncol = 0;
    for (int i = 0; i < 8; i++) begin
      fx_col0[i] = 0;
      fx_col_goal[i] = 0;
      fx_col[i] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed part, colours over the whole fade
    write_effect(32'd0);
    foreach (dir_rows[k]) begin
      r = dir_rows[k];
      send_req(r.rq, r.slot, r.val, r.tb, r.cnt, r.dur, r.now_v);
      if (r.chk && (pending_words[$].bri !== r.bri || pending_words[$].act !== r.act)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: predicted bri %0d act %b, row says %0d %b",
                   k, pending_words[$].bri, pending_words[$].act, r.bri, r.act);
      end
    end

    // random part over several effect times, extremes included
    effects = '{32'd1, 32'hFFFF_FFFF, 32'd0, $urandom_range(1, 1500)};
    foreach (effects[ph]) begin
      write_effect(effects[ph]);
      stall_quiet = (ph == 2);
      while (items_sent < dir_rows.size() + (ph + 1) * RandItems / 4) begin
        random_fade();
        // hold off the sender until all results are back
        if (ph == 1 && $urandom_range(0, 3) == 0) drain_results();
      end
    end

    drain_results();
    repeat (300) @(posedge clk);
    $display("run: %0d requests, %0d result words, %0d fades started, 4 effect times",
             items_sent, words_seen, fades);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
